/* hw/rtl/pca_pkg.sv */
// Shared types, widths and the standard colour table of the palette allocator.
package pca_pkg;

  typedef logic [7:0] comp8_t;
  typedef logic [5:0] comp6_t;
  typedef logic [7:0] pal_idx_t;

  typedef struct packed {
    comp6_t red;
    comp6_t green;
    comp6_t blue;
  } color_t;

  localparam color_t STD_COLORS [16] = '{
    '{6'd0,  6'd0,  6'd0 }, '{6'd0,  6'd0,  6'd42}, '{6'd0,  6'd42, 6'd0 }, '{6'd0,  6'd42, 6'd42},
    '{6'd42, 6'd0,  6'd0 }, '{6'd42, 6'd0,  6'd42}, '{6'd42, 6'd21, 6'd0 }, '{6'd42, 6'd42, 6'd42},
    '{6'd21, 6'd21, 6'd21}, '{6'd21, 6'd21, 6'd63}, '{6'd21, 6'd63, 6'd21}, '{6'd21, 6'd63, 6'd63},
    '{6'd63, 6'd21, 6'd21}, '{6'd63, 6'd21, 6'd63}, '{6'd63, 6'd63, 6'd21}, '{6'd63, 6'd63, 6'd63}
  };

  function automatic color_t std_color(input logic [3:0] idx);
    return STD_COLORS[idx];
  endfunction

endpackage

/* hw/rtl/pca_if.sv */
// Valid/ready channel interfaces for colour requests and allocation results.
interface pca_in_if import pca_pkg::*; ;
  logic   valid;
  logic   ready;
  comp8_t red_in;
  comp8_t green_in;
  comp8_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface pca_out_if import pca_pkg::*; ;
  logic     valid;
  logic     ready;
  pal_idx_t slot_index;
  logic     dac_update;
  comp6_t   red_six;
  comp6_t   green_six;
  comp6_t   blue_six;

  modport source (output valid, output slot_index, output dac_update, output red_six,
                  output green_six, output blue_six, input ready);
  modport sink   (input valid, input slot_index, input dac_update, input red_six,
                  input green_six, input blue_six, output ready);
endinterface

/* hw/rtl/palette_color_allocator_lfu.sv */
// Palette colour allocator with least-frequently-used replacement, top level.
//
// A request word on in_ch carries an 8-bit red, green and blue value; the
// upper six bits of each are looked up in a palette of PALETTE_ENTRIES
// entries held in one synchronous memory with a usage count per entry.
// Each request yields one result word on out_ch: the palette index that now
// holds the colour, a DAC update flag when the colour was newly stored, and the
// six-bit colour.
// A request is taken only when the allocator is idle. It then reads every
// entry in turn through the single memory read port, tracking the first
// match, the first free entry and the least-used entry, and writes the
// chosen entry back once. Each request passes through the scan, drain and
// write states before the allocator is idle again; the result word is
// registered with the write-back.
// The result sits in an output register; a new request is accepted while
// it waits, but the write-back of that request holds until out_ch is free.
// Reset clears the per-entry valid flags at once, so the palette returns to
// the standard colours in the fixed entries and free entries elsewhere.
module palette_color_allocator_lfu import pca_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int FIXED_ENTRIES   = 16,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  pca_in_if.sink           in_ch,
  pca_out_if.source        out_ch
);

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int EW = $bits(color_t) + COUNT_WIDTH;
  localparam logic [IW-1:0] LAST_IDX  = IW'(PALETTE_ENTRIES - 1);
  localparam logic [IW-1:0] FIXED_IDX = IW'(FIXED_ENTRIES);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  logic [EW-1:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid_r;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] rd_addr_r;
  logic [EW-1:0] rdata_r;
  logic          rvld_r;
  logic [IW-1:0] ridx_r;
  logic          pipe_v_r;
  color_t        want_r;

  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  count_t        hit_cnt_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic          min_have_r;
  count_t        min_cnt_r;
  logic [IW-1:0] min_idx_r;

  logic          out_valid_r;
  pal_idx_t      slot_index_r;
  logic          dac_update_r;
  color_t        out_color_r;

  color_t        eff_col;
  count_t        eff_cnt;
  logic          in_acc;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  count_t        wr_cnt;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign wr_en       = (state_r == ST_WRITE) && (!out_valid_r || out_ch.ready);
  assign wr_addr     = hit_r ? hit_idx_r : (free_r ? free_idx_r : min_idx_r);
  assign wr_cnt      = hit_r ? ((hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + CNT_ONE) : CNT_ONE;

  always_comb begin
    if (rvld_r) begin
      eff_col = color_t'(rdata_r[EW-1:COUNT_WIDTH]);
      eff_cnt = rdata_r[COUNT_WIDTH-1:0];
    end else if (ridx_r < FIXED_IDX) begin
      eff_col = std_color(ridx_r[3:0]);
      eff_cnt = CNT_ONE;
    end else begin
      eff_col = '0;
      eff_cnt = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:  if (rd_addr_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_WRITE;
      ST_WRITE: if (wr_en) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {want_r, wr_cnt};
    end
    rdata_r <= mem[rd_addr_r];
    rvld_r  <= valid_r[rd_addr_r];
    ridx_r  <= rd_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      pipe_v_r    <= 1'b0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pipe_v_r <= (state_r == ST_SCAN);
      if (in_acc) begin
        rd_addr_r <= '0;
      end else if (state_r == ST_SCAN && rd_addr_r != LAST_IDX) begin
        rd_addr_r <= rd_addr_r + IW'(1);
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      want_r     <= '{in_ch.red_in[7:2], in_ch.green_in[7:2], in_ch.blue_in[7:2]};
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      min_have_r <= 1'b0;
    end else if (pipe_v_r) begin
      if (!hit_r && eff_cnt != '0 && eff_col == want_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= ridx_r;
        hit_cnt_r <= eff_cnt;
      end
      if (ridx_r >= FIXED_IDX) begin
        if (!free_r && eff_cnt == '0) begin
          free_r     <= 1'b1;
          free_idx_r <= ridx_r;
        end
        if (!min_have_r || eff_cnt < min_cnt_r) begin
          min_have_r <= 1'b1;
          min_cnt_r  <= eff_cnt;
          min_idx_r  <= ridx_r;
        end
      end
    end
    if (wr_en) begin
      slot_index_r <= pal_idx_t'(wr_addr);
      dac_update_r <= !hit_r;
      out_color_r  <= want_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = slot_index_r;
  assign out_ch.dac_update = dac_update_r;
  assign out_ch.red_six    = out_color_r.red;
  assign out_ch.green_six  = out_color_r.green;
  assign out_ch.blue_six   = out_color_r.blue;

  a_miss_not_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !hit_r |-> wr_addr >= FIXED_IDX)
    else $error("miss write-back targets a fixed entry");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SCAN && rd_addr_r == '0)
    else $error("scan did not start at entry zero");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_v_r |-> state_r == ST_SCAN || state_r == ST_DRAIN)
    else $error("read data processed outside the scan");

endmodule

/* tb/tb_palette_color_allocator_lfu.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the LFU palette colour allocator, with directed and random requests.
module tb import pca_pkg::*; ;

  localparam int PAL_ENTRIES  = 256;
  localparam int FIXED_SLOTS  = 16;
  localparam int COUNT_W      = 16;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    pal_idx_t index;
    logic     dac;
    comp6_t   red;
    comp6_t   green;
    comp6_t   blue;
  } alloc_t;

  logic clk = 1'b0;
  logic rst_n;

  pca_in_if  in_ch ();
  pca_out_if out_ch ();

  palette_color_allocator_lfu #(
    .PALETTE_ENTRIES(PAL_ENTRIES),
    .FIXED_ENTRIES  (FIXED_SLOTS),
    .COUNT_WIDTH    (COUNT_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  color_t               pal_color [PAL_ENTRIES];
  logic [COUNT_W-1:0]   pal_uses  [PAL_ENTRIES];
  alloc_t               expected_allocs [$];

  int mismatches     = 0;
  int allocs_checked = 0;
  int hits_seen      = 0;
  int fills_seen     = 0;
  int evictions_seen = 0;
  int cycle_count    = 0;
  bit idling_on      = 1'b1;

  // Works out the allocation for one accepted request and updates the palette copy.
  task automatic predict_allocation(input comp8_t r, input comp8_t g, input comp8_t b);
    color_t             want;
    int                 hit_slot;
    int                 free_slot;
    int                 victim_slot;
    int                 slot;
    logic [COUNT_W-1:0] least;
    alloc_t             res;
    want        = '{r[7:2], g[7:2], b[7:2]};
    hit_slot    = -1;
    free_slot   = -1;
    victim_slot = FIXED_SLOTS;
    least       = pal_uses[FIXED_SLOTS];
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      if (hit_slot < 0 && pal_uses[i] != '0 && pal_color[i] == want) hit_slot = i;
      if (i >= FIXED_SLOTS) begin
        if (free_slot < 0 && pal_uses[i] == '0) free_slot = i;
        if (pal_uses[i] < least) begin
          least       = pal_uses[i];
          victim_slot = i;
        end
      end
    end
    if (hit_slot >= 0) begin
      slot = hit_slot;
      if (pal_uses[slot] != '1) pal_uses[slot] = pal_uses[slot] + 1'b1;
      hits_seen++;
    end else begin
      if (free_slot >= 0) begin
        slot = free_slot;
        fills_seen++;
      end else begin
        slot = victim_slot;
        evictions_seen++;
      end
      pal_color[slot] = want;
      pal_uses[slot]  = COUNT_W'(1);
    end
    res.index = pal_idx_t'(slot);
    res.dac   = (hit_slot < 0);
    res.red   = want.red;
    res.green = want.green;
    res.blue  = want.blue;
    expected_allocs.push_back(res);
  endtask

  task automatic send_request(input comp8_t r, input comp8_t g, input comp8_t b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_allocation(r, g, b);
  endtask

  // Requests the colour held in a slot, with random bits below the six that count.
  task automatic send_stored(input int slot);
    color_t     c;
    logic [5:0] noise;
    c     = pal_color[slot];
    noise = 6'($urandom);
    send_request({c.red, noise[1:0]}, {c.green, noise[3:2]}, {c.blue, noise[5:4]});
  endtask

  function automatic int pick_stored_slot(input bit favour_low);
    int slot;
    for (int tries = 0; tries < 64; tries++) begin
      slot = favour_low ? $urandom_range(FIXED_SLOTS, FIXED_SLOTS + 15)
                        : $urandom_range(0, PAL_ENTRIES - 1);
      if (pal_uses[slot] != '0) return slot;
    end
    return $urandom_range(0, FIXED_SLOTS - 1);
  endfunction

  task automatic send_mixed(input int hit_pct, input int std_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < hit_pct)
      send_stored(pick_stored_slot($urandom_range(0, 2) == 0));
    else if (pick < hit_pct + std_pct)
      send_stored($urandom_range(0, FIXED_SLOTS - 1));
    else
      send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
  endtask

  task automatic test_standard_colours();
    for (int i = 0; i < FIXED_SLOTS; i++) send_stored(i);
  endtask

  task automatic test_fill_and_hit();
    send_request(8'h00, 8'h00, 8'h00);
    send_request(8'hFF, 8'hFF, 8'hFF);
    send_request(8'hFF, 8'h00, 8'h80);
    send_request(8'hFC, 8'h03, 8'h83);
    send_request(8'h01, 8'h02, 8'h03);
    send_request(8'h80, 8'h80, 8'h80);
    send_request(8'h7F, 8'h7F, 8'h7F);
    send_request(8'h80, 8'h81, 8'h82);
  endtask

  // Mostly new colours, so that the free entries run out and eviction begins.
  task automatic test_palette_fill();
    repeat (330) send_mixed(10, 5);
  endtask

  task automatic test_replacement();
    repeat (950) send_mixed(45, 10);
  endtask

  task automatic test_back_to_back();
    repeat (280) send_mixed(40, 10);
  endtask

  task automatic log_mismatch(input string what, input alloc_t exp, input alloc_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: exp index %0d dac %0b rgb %0d/%0d/%0d,",
               what, exp.index, exp.dac, exp.red, exp.green, exp.blue,
               " got index %0d dac %0b rgb %0d/%0d/%0d",
               got.index, got.dac, got.red, got.green, got.blue);
  endtask

  always @(posedge clk) begin : check_results
    alloc_t got;
    alloc_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.slot_index, out_ch.dac_update, out_ch.red_six, out_ch.green_six,
              out_ch.blue_six};
      if (expected_allocs.size() == 0) begin
        log_mismatch("unexpected word", 'x, got);
      end else begin
        exp = expected_allocs.pop_front();
        allocs_checked++;
        if (got !== exp) log_mismatch("wrong word", exp, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("palette_color_allocator_lfu verification failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if (idling_on) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.red_in   <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in  <= '0;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      pal_color[i] = (i < FIXED_SLOTS) ? STD_COLORS[i] : '0;
      pal_uses[i]  = (i < FIXED_SLOTS) ? COUNT_W'(1) : '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_standard_colours();
    test_fill_and_hit();
    test_palette_fill();
    test_replacement();
    idling_on = 1'b0;
    test_back_to_back();
    in_ch.valid <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d allocations: %0d hits, %0d fills of free entries, %0d evictions.",
             allocs_checked, hits_seen, fills_seen, evictions_seen);
    $display("Mismatches seen: %0d, cycles run: %0d.", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("palette_color_allocator_lfu verification clean");
    end else begin
      $display("palette_color_allocator_lfu verification failed");
    end
    $finish;
  end

endmodule
